FILE: src/trun_dp_pkg.sv
// Shared types, constants and helpers for the track-run box duration parser.
package trun_dp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_COUNT  = 3'd1,
        PH_DOFF   = 3'd2,
        PH_FFLAGS = 3'd3,
        PH_SAMPLE = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    localparam logic [23:0] FLAG_DATA_OFFSET = 24'h000001;
    localparam logic [23:0] FLAG_FIRST_FLAGS = 24'h000004;
    // per-sample field enables sit at flag bits 8..11
    localparam int unsigned SAMPLE_FLAG_LSB  = 8;
    localparam logic [2:0]  FIELD_NONE       = 3'd4;

    typedef struct packed {
        logic [7:0]  box_version;
        logic [23:0] box_flags;
        logic [31:0] samples_declared;
        logic [31:0] duration_sum;
        logic        truncated;
    } t_result;

    // First enabled per-sample field at index >= start, FIELD_NONE if none.
    function automatic logic [2:0] next_field(input logic [3:0] en, input logic [2:0] start);
        logic [2:0] res;
        res = FIELD_NONE;
        for (int i = 3; i >= 0; i--) begin
            if (en[i] && (3'(i) >= start)) begin
                res = 3'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: src/trun_dp_parse.sv
// Parse state of one track-run box: field tracking, latched header fields, duration sum.
module trun_dp_parse
    import trun_dp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output t_result     o_result
);

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_biw,    n_biw;
    logic [31:0] r_word,   n_word;
    logic [7:0]  r_ver,    n_ver;
    logic [23:0] r_flags,  n_flags;
    logic [31:0] r_count,  n_count;
    logic [31:0] r_left,   n_left;
    logic [1:0]  r_field,  n_field;
    logic [31:0] r_sum,    n_sum;

    logic [31:0] w_word;
    logic [3:0]  w_en;
    logic [2:0]  w_first;
    logic [2:0]  w_after;
    logic        w_active;

    assign w_word   = {r_word[23:0], i_data_byte};
    assign w_en     = r_flags[SAMPLE_FLAG_LSB +: 4];
    assign w_first  = next_field(w_en, 3'd0);
    assign w_after  = next_field(w_en, {1'b0, r_field} + 3'd1);
    assign w_active = (r_phase == PH_HEADER) || (r_phase == PH_COUNT) ||
                      (r_phase == PH_DOFF) || (r_phase == PH_FFLAGS) ||
                      (r_phase == PH_SAMPLE);

    // state after this byte, before the end-of-box reset
    always_comb begin
        n_phase = r_phase;
        n_biw   = r_biw;
        n_word  = r_word;
        n_ver   = r_ver;
        n_flags = r_flags;
        n_count = r_count;
        n_left  = r_left;
        n_field = r_field;
        n_sum   = r_sum;
        if (i_step && w_active) begin
            n_word = w_word;
            n_biw  = r_biw + 2'd1;
            if (r_biw == 2'd3) begin
                case (r_phase)
                    PH_HEADER: begin
                        n_ver   = w_word[31:24];
                        n_flags = w_word[23:0];
                        n_phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_count = w_word;
                        n_left  = w_word;
                        if ((r_flags & FLAG_DATA_OFFSET) != '0) begin
                            n_phase = PH_DOFF;
                        end else if ((r_flags & FLAG_FIRST_FLAGS) != '0) begin
                            n_phase = PH_FFLAGS;
                        end else if ((w_word == '0) || (w_first == FIELD_NONE)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_SAMPLE;
                            n_field = w_first[1:0];
                        end
                    end
                    PH_DOFF: begin
                        if ((r_flags & FLAG_FIRST_FLAGS) != '0) begin
                            n_phase = PH_FFLAGS;
                        end else if ((r_left == '0) || (w_first == FIELD_NONE)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_SAMPLE;
                            n_field = w_first[1:0];
                        end
                    end
                    PH_FFLAGS: begin
                        if ((r_left == '0) || (w_first == FIELD_NONE)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_SAMPLE;
                            n_field = w_first[1:0];
                        end
                    end
                    PH_SAMPLE: begin
                        if (r_field == 2'd0) begin
                            n_sum = r_sum + w_word;
                        end
                        if (w_after == FIELD_NONE) begin
                            n_left = r_left - 32'd1;
                            if (r_left == 32'd1) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_field = w_first[1:0];
                            end
                        end else begin
                            n_field = w_after[1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.box_version      = n_ver;
        o_result.box_flags        = n_flags;
        o_result.samples_declared = n_count;
        o_result.duration_sum     = n_sum;
        o_result.truncated        = (n_phase != PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_phase <= PH_HEADER;
            r_biw   <= '0;
            r_word  <= '0;
            r_ver   <= '0;
            r_flags <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_field <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_biw   <= n_biw;
            r_word  <= n_word;
            r_ver   <= n_ver;
            r_flags <= n_flags;
            r_count <= n_count;
            r_left  <= n_left;
            r_field <= n_field;
            r_sum   <= n_sum;
        end
    end

endmodule

FILE: src/trun_box_duration_parser_top.sv
// Track-run box duration parser: one payload byte per request in, one summary per box out.
// A byte is registered in the input stage on acceptance and parsed from there; the summary
// for a box is registered in the output register when its last byte is parsed.
// Throughput: one byte per cycle; the input stage only stalls when a last byte waits
// on a full, unaccepted output register.
// Reset (i_rst_n low, synchronous) empties both stages and returns the parser to the header.
module trun_box_duration_parser_top
    import trun_dp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_box_version,
    output logic [23:0] o_box_flags,
    output logic [31:0] o_samples_declared,
    output logic [31:0] o_duration_sum,
    output logic        o_truncated
);

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_result;
    logic        w_step;

    // a last byte needs room in the output register; other bytes always advance
    assign w_step     = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    trun_dp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_data_byte (r_in_data),
        .i_last_byte (r_in_last),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_box_version      = r_out.box_version;
    assign o_box_flags        = r_out.box_flags;
    assign o_samples_declared = r_out.samples_declared;
    assign o_duration_sum     = r_out.duration_sum;
    assign o_truncated        = r_out.truncated;

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid)
        else $error("input stage stalled while empty");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid && r_in_last))
        else $error("result produced without a last byte");

    a_result_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !(w_step && r_in_last)) |=> !o_out_valid)
        else $error("result repeated after being taken");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && r_in_valid && r_in_last) |-> !w_step)
        else $error("pending result overwritten");

endmodule
